FILE: rtl/psc_pkg.sv
// package for the pinned slot cache directory
// widths, command and status codes, datapath op codes and controller-datapath structs
package psc_pkg;

  localparam int NUM_SLOTS  = 256;
  localparam int MAX_OWNERS = 16;
  localparam int MAX_LINES  = 1024;
  localparam int PIN_BITS   = 16;

  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int LINK_DEPTH = NUM_SLOTS + 1;
  localparam int LINK_W     = $clog2(LINK_DEPTH);
  localparam int OWN_W      = $clog2(MAX_OWNERS);
  localparam int LINE_W     = $clog2(MAX_LINES);
  localparam int KEY_W      = OWN_W + LINE_W;
  localparam int MAP_DEPTH  = MAX_OWNERS * MAX_LINES;
  localparam int MAP_W      = SLOT_W + 1;
  localparam int CLR_W      = $clog2(MAP_DEPTH);
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
  localparam int PIN_W      = PIN_BITS;
  localparam int CMD_W      = 2;
  localparam int ST_W       = 3;

  localparam logic [PIN_W-1:0] PIN_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_LOOKUP      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNPIN       = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVICT_OWNER = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EVICT_ALL   = 2'd3;

  localparam logic [ST_W-1:0] ST_HIT        = 3'd0;
  localparam logic [ST_W-1:0] ST_MISS       = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_SPACE   = 3'd2;
  localparam logic [ST_W-1:0] ST_PIN_OVF    = 3'd3;
  localparam logic [ST_W-1:0] ST_UNPIN_FREE = 3'd4;
  localparam logic [ST_W-1:0] ST_EVICT_PART = 3'd5;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_LK_SEL,
    OP_LK_UNL1,
    OP_LK_UNL2,
    OP_PIN_INC,
    OP_PIN_DEC,
    OP_MISS1,
    OP_MISS2,
    OP_UP_LNK1,
    OP_UP_LNK2,
    OP_EV_READ,
    OP_EV_UNL,
    OP_EV_HEAD,
    OP_EV_W1,
    OP_EV_W2
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            scan_inc;
    logic            out_load;
    logic [ST_W-1:0] status;
  } psc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic refuse;
    logic hit;
    logic head_zero;
    logic pin_zero;
    logic pin_one;
    logic pin_max;
    logic scan_valid;
    logic scan_match;
    logic scan_last;
    logic out_free;
  } psc_sts_t;

endpackage

FILE: rtl/psc_if.sv
// request and response channel interfaces of the slot cache directory
// depends on psc_pkg for field widths
interface psc_in_if;
  logic                        valid;
  logic                        ready;
  logic [psc_pkg::CMD_W-1:0]   cmd;
  logic [psc_pkg::OWN_W-1:0]   owner_id;
  logic [psc_pkg::LINE_W-1:0]  line_index;
  logic [psc_pkg::SLOT_W-1:0]  slot_index;
  logic [psc_pkg::CNT_W-1:0]   lines_needed;

  modport source (output valid, cmd, owner_id, line_index, slot_index, lines_needed,
                  input ready);
  modport sink (input valid, cmd, owner_id, line_index, slot_index, lines_needed,
                output ready);
endinterface

interface psc_out_if;
  logic                        valid;
  logic                        ready;
  logic [psc_pkg::ST_W-1:0]    status;
  logic [psc_pkg::SLOT_W-1:0]  slot_out;
  logic                        evicted_valid;
  logic [psc_pkg::OWN_W-1:0]   evicted_owner;
  logic [psc_pkg::LINE_W-1:0]  evicted_line;
  logic [psc_pkg::CNT_W-1:0]   free_slots;

  modport source (output valid, status, slot_out, evicted_valid, evicted_owner,
                  evicted_line, free_slots, input ready);
  modport sink (input valid, status, slot_out, evicted_valid, evicted_owner,
                evicted_line, free_slots, output ready);
endinterface

FILE: rtl/psc_ctrl.sv
// controller state machine of the slot cache directory
// sequences datapath ops per command; depends on psc_pkg
module psc_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [psc_pkg::CMD_W-1:0]  in_cmd_i,
  output logic                       in_ready_o,
  input  psc_pkg::psc_sts_t          sts_i,
  output psc_pkg::psc_cmd_t          cmd_o
);
  import psc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LK_SEL, S_LK_DEC, S_LK_UNL2, S_MISS2, S_UP_DEC, S_UP_LNK2,
    S_EV_CHK, S_EV_DEC, S_EV_HEAD, S_EV_W1, S_EV_W2, S_FIN
  } state_e;

  state_e          state_q, state_d;
  logic [ST_W-1:0] st_q, st_d;
  logic            inc_q, inc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      st_q    <= ST_HIT;
      inc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      inc_q   <= inc_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    logic inc_n;
    inc_n          = inc_q;
    state_d        = state_q;
    st_d           = st_q;
    inc_d          = inc_q;
    cmd_o.op       = OP_NONE;
    cmd_o.scan_inc = 1'b0;
    cmd_o.out_load = 1'b0;
    cmd_o.status   = st_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          inc_d    = 1'b0;
          case (in_cmd_i)
            CMD_LOOKUP: state_d = S_LK_SEL;
            CMD_UNPIN:  state_d = S_UP_DEC;
            default:    state_d = S_EV_CHK;
          endcase
        end
      end
      S_LK_SEL: begin
        cmd_o.op = OP_LK_SEL;
        if (sts_i.refuse || (!sts_i.hit && sts_i.head_zero)) begin
          st_d    = ST_NO_SPACE;
          state_d = S_FIN;
        end else begin
          state_d = S_LK_DEC;
        end
      end
      S_LK_DEC: begin
        if (sts_i.hit) begin
          if (sts_i.pin_zero) begin
            cmd_o.op = OP_LK_UNL1;
            state_d  = S_LK_UNL2;
          end else if (sts_i.pin_max) begin
            st_d    = ST_PIN_OVF;
            state_d = S_FIN;
          end else begin
            cmd_o.op = OP_PIN_INC;
            st_d     = ST_HIT;
            state_d  = S_FIN;
          end
        end else begin
          cmd_o.op = OP_MISS1;
          state_d  = S_MISS2;
        end
      end
      S_LK_UNL2: begin
        cmd_o.op = OP_LK_UNL2;
        st_d     = ST_HIT;
        state_d  = S_FIN;
      end
      S_MISS2: begin
        cmd_o.op = OP_MISS2;
        st_d     = ST_MISS;
        state_d  = S_FIN;
      end
      S_UP_DEC: begin
        if (sts_i.pin_zero) begin
          st_d    = ST_UNPIN_FREE;
          state_d = S_FIN;
        end else if (sts_i.pin_one) begin
          cmd_o.op = OP_UP_LNK1;
          state_d  = S_UP_LNK2;
        end else begin
          cmd_o.op = OP_PIN_DEC;
          st_d     = ST_HIT;
          state_d  = S_FIN;
        end
      end
      S_UP_LNK2: begin
        cmd_o.op = OP_UP_LNK2;
        st_d     = ST_HIT;
        state_d  = S_FIN;
      end
      S_EV_CHK: begin
        if (sts_i.scan_valid) begin
          cmd_o.op = OP_EV_READ;
          state_d  = S_EV_DEC;
        end else begin
          cmd_o.scan_inc = 1'b1;
          if (sts_i.scan_last) begin
            st_d    = inc_q ? ST_EVICT_PART : ST_HIT;
            state_d = S_FIN;
          end
        end
      end
      S_EV_DEC: begin
        if (sts_i.scan_match && sts_i.pin_zero) begin
          cmd_o.op = OP_EV_UNL;
          state_d  = S_EV_HEAD;
        end else begin
          inc_n          = inc_q | sts_i.scan_match;
          inc_d          = inc_n;
          cmd_o.scan_inc = 1'b1;
          if (sts_i.scan_last) begin
            st_d    = inc_n ? ST_EVICT_PART : ST_HIT;
            state_d = S_FIN;
          end else begin
            state_d = S_EV_CHK;
          end
        end
      end
      S_EV_HEAD: begin
        cmd_o.op = OP_EV_HEAD;
        state_d  = S_EV_W1;
      end
      S_EV_W1: begin
        cmd_o.op = OP_EV_W1;
        state_d  = S_EV_W2;
      end
      S_EV_W2: begin
        cmd_o.op       = OP_EV_W2;
        cmd_o.scan_inc = 1'b1;
        if (sts_i.scan_last) begin
          st_d    = inc_q ? ST_EVICT_PART : ST_HIT;
          state_d = S_FIN;
        end else begin
          state_d = S_EV_CHK;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/psc_dp.sv
// datapath of the slot cache directory: link, pin, tag and line map memories,
// free count, scan counter and result register; depends on psc_pkg
module psc_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  psc_pkg::psc_cmd_t          cmd_i,
  output psc_pkg::psc_sts_t          sts_o,
  input  logic [psc_pkg::CMD_W-1:0]  in_cmd_i,
  input  logic [psc_pkg::OWN_W-1:0]  in_owner_i,
  input  logic [psc_pkg::LINE_W-1:0] in_line_i,
  input  logic [psc_pkg::SLOT_W-1:0] in_slot_i,
  input  logic [psc_pkg::CNT_W-1:0]  in_need_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [psc_pkg::ST_W-1:0]   out_status_o,
  output logic [psc_pkg::SLOT_W-1:0] out_slot_o,
  output logic                       out_ev_valid_o,
  output logic [psc_pkg::OWN_W-1:0]  out_ev_owner_o,
  output logic [psc_pkg::LINE_W-1:0] out_ev_line_o,
  output logic [psc_pkg::CNT_W-1:0]  out_free_o
);
  import psc_pkg::*;

  logic [LINK_W-1:0] next_mem [LINK_DEPTH];
  logic [LINK_W-1:0] prev_mem [LINK_DEPTH];
  logic [PIN_W-1:0]  pin_mem  [LINK_DEPTH];
  logic [KEY_W-1:0]  tag_mem  [NUM_SLOTS];
  logic [MAP_W-1:0]  map_mem  [MAP_DEPTH];

  logic [NUM_SLOTS-1:0] tag_valid_q;
  logic [CNT_W-1:0]     free_q;
  logic [CLR_W-1:0]     clr_q;
  logic                 out_valid_q;

  logic [CMD_W-1:0]  cmd_q;
  logic [OWN_W-1:0]  owner_q;
  logic [LINE_W-1:0] line_q;
  logic [CNT_W-1:0]  need_q;
  logic [LINK_W-1:0] e_q;
  logic [SLOT_W-1:0] slot_q, slot_res_q, scan_q;
  logic              tagv_q, ev_valid_q;
  logic [MAP_W-1:0]  map_rd_q;
  logic [LINK_W-1:0] next_rd_q, prev_rd_q;
  logic [PIN_W-1:0]  pin_rd_q;
  logic [KEY_W-1:0]  tag_rd_q;
  logic [ST_W-1:0]   out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_ev_valid_q;
  logic [OWN_W-1:0]  out_ev_owner_q;
  logic [LINE_W-1:0] out_ev_line_q;
  logic [CNT_W-1:0]  out_free_q;

  logic              hit, head_zero, refuse;
  logic [SLOT_W-1:0] slot_sel;
  logic [LINK_W-1:0] e_sel, scan_e, sidx_e, clr_link;
  logic              clr_link_en;

  logic              next_re, prev_re, pin_re, tag_re, map_re;
  logic [LINK_W-1:0] next_ra, prev_ra, pin_ra;
  logic [SLOT_W-1:0] tag_ra;
  logic [KEY_W-1:0]  map_ra;
  logic              next_we, prev_we, pin_we, tag_we, map_we;
  logic [LINK_W-1:0] next_wa, next_wd, prev_wa, prev_wd, pin_wa;
  logic [PIN_W-1:0]  pin_wd;
  logic [KEY_W-1:0]  map_wa;
  logic [MAP_W-1:0]  map_wd;

  assign hit       = map_rd_q[MAP_W-1];
  assign head_zero = (next_rd_q == '0);
  assign refuse    = (free_q == '0) || (free_q < need_q);
  assign slot_sel  = hit ? map_rd_q[SLOT_W-1:0] : SLOT_W'(next_rd_q - LINK_W'(1));
  assign e_sel     = hit ? ({1'b0, map_rd_q[SLOT_W-1:0]} + LINK_W'(1)) : next_rd_q;
  assign scan_e    = {1'b0, scan_q} + LINK_W'(1);
  assign sidx_e    = {1'b0, in_slot_i} + LINK_W'(1);
  assign clr_link  = clr_q[LINK_W-1:0];
  assign clr_link_en = (clr_q < CLR_W'(LINK_DEPTH));

  always_comb begin
    next_re = 1'b0; prev_re = 1'b0; pin_re = 1'b0; tag_re = 1'b0; map_re = 1'b0;
    next_ra = e_sel; prev_ra = e_sel; pin_ra = e_sel; tag_ra = slot_sel;
    map_ra  = {in_owner_i, in_line_i};
    case (cmd_i.op)
      OP_ACCEPT: begin
        map_re = 1'b1; next_re = 1'b1; prev_re = 1'b1; pin_re = 1'b1;
        next_ra = '0; prev_ra = '0; pin_ra = sidx_e;
      end
      OP_LK_SEL: begin
        next_re = 1'b1; prev_re = 1'b1; pin_re = 1'b1; tag_re = 1'b1;
      end
      OP_EV_READ: begin
        next_re = 1'b1; prev_re = 1'b1; pin_re = 1'b1; tag_re = 1'b1;
        next_ra = scan_e; prev_ra = scan_e; pin_ra = scan_e; tag_ra = scan_q;
      end
      OP_EV_HEAD: begin
        next_re = 1'b1; next_ra = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    next_we = 1'b0; prev_we = 1'b0; pin_we = 1'b0; tag_we = 1'b0; map_we = 1'b0;
    next_wa = e_q; next_wd = e_q; prev_wa = e_q; prev_wd = e_q;
    pin_wa  = e_q; pin_wd = '0;
    map_wa  = tag_rd_q; map_wd = '0;
    case (cmd_i.op)
      OP_CLEAR: begin
        map_we  = 1'b1; map_wa = clr_q;
        next_we = clr_link_en; prev_we = clr_link_en; pin_we = clr_link_en;
        next_wa = clr_link; prev_wa = clr_link; pin_wa = clr_link;
        next_wd = (clr_link == LINK_W'(NUM_SLOTS)) ? '0 : clr_link + LINK_W'(1);
        prev_wd = (clr_link == '0) ? LINK_W'(NUM_SLOTS) : clr_link - LINK_W'(1);
      end
      OP_LK_UNL1, OP_MISS1, OP_EV_UNL: begin
        next_we = 1'b1; next_wa = prev_rd_q; next_wd = next_rd_q;
        prev_we = 1'b1; prev_wa = next_rd_q; prev_wd = prev_rd_q;
        if (cmd_i.op != OP_EV_UNL) begin
          pin_we = 1'b1; pin_wd = PIN_W'(1);
        end
        if (cmd_i.op == OP_MISS1) begin
          tag_we = 1'b1;
          map_we = tagv_q;
        end
        if (cmd_i.op == OP_EV_UNL) map_we = 1'b1;
      end
      OP_LK_UNL2: begin
        next_we = 1'b1; prev_we = 1'b1;
      end
      OP_MISS2: begin
        next_we = 1'b1; prev_we = 1'b1;
        map_we = 1'b1; map_wa = {owner_q, line_q}; map_wd = {1'b1, slot_q};
      end
      OP_PIN_INC: begin
        pin_we = 1'b1; pin_wd = pin_rd_q + PIN_W'(1);
      end
      OP_PIN_DEC: begin
        pin_we = 1'b1; pin_wd = pin_rd_q - PIN_W'(1);
      end
      OP_UP_LNK1: begin
        next_we = 1'b1; next_wd = '0;
        prev_we = 1'b1; prev_wd = prev_rd_q;
        pin_we  = 1'b1;
      end
      OP_UP_LNK2: begin
        next_we = 1'b1; next_wa = prev_rd_q; next_wd = e_q;
        prev_we = 1'b1; prev_wa = '0; prev_wd = e_q;
      end
      OP_EV_W1: begin
        next_we = 1'b1; next_wd = next_rd_q;
        prev_we = 1'b1; prev_wa = next_rd_q; prev_wd = e_q;
      end
      OP_EV_W2: begin
        next_we = 1'b1; next_wa = '0; next_wd = e_q;
        prev_we = 1'b1; prev_wd = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_rd_q <= next_mem[next_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) prev_rd_q <= prev_mem[prev_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pin_we) pin_mem[pin_wa] <= pin_wd;
    if (pin_re) pin_rd_q <= pin_mem[pin_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[slot_q] <= {owner_q, line_q};
    if (tag_re) tag_rd_q <= tag_mem[tag_ra];
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (map_re) map_rd_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_valid_q <= '0;
      free_q      <= CNT_W'(NUM_SLOTS);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_CLEAR) clr_q <= clr_q + CLR_W'(1);
      if (cmd_i.op == OP_LK_UNL1 || cmd_i.op == OP_MISS1) free_q <= free_q - CNT_W'(1);
      if (cmd_i.op == OP_UP_LNK1) free_q <= free_q + CNT_W'(1);
      if (cmd_i.op == OP_MISS1) tag_valid_q[slot_q] <= 1'b1;
      if (cmd_i.op == OP_EV_UNL) tag_valid_q[scan_q] <= 1'b0;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        cmd_q      <= in_cmd_i;
        owner_q    <= in_owner_i;
        line_q     <= in_line_i;
        need_q     <= in_need_i;
        e_q        <= sidx_e;
        scan_q     <= '0;
        ev_valid_q <= 1'b0;
        slot_res_q <= (in_cmd_i == CMD_UNPIN) ? in_slot_i : '0;
      end
      OP_LK_SEL: begin
        e_q        <= e_sel;
        slot_q     <= slot_sel;
        tagv_q     <= tag_valid_q[slot_sel];
        slot_res_q <= (refuse || (!hit && head_zero)) ? '0 : slot_sel;
      end
      OP_MISS1:   ev_valid_q <= tagv_q;
      OP_EV_READ: e_q <= scan_e;
      default: ;
    endcase
    if (cmd_i.scan_inc) scan_q <= scan_q + SLOT_W'(1);
    if (cmd_i.out_load) begin
      out_status_q   <= cmd_i.status;
      out_slot_q     <= slot_res_q;
      out_ev_valid_q <= ev_valid_q;
      out_ev_owner_q <= ev_valid_q ? tag_rd_q[KEY_W-1 -: OWN_W] : '0;
      out_ev_line_q  <= ev_valid_q ? tag_rd_q[LINE_W-1:0] : '0;
      out_free_q     <= free_q;
    end
  end

  assign sts_o.clr_last   = (clr_q == '1);
  assign sts_o.refuse     = refuse;
  assign sts_o.hit        = hit;
  assign sts_o.head_zero  = head_zero;
  assign sts_o.pin_zero   = (pin_rd_q == '0);
  assign sts_o.pin_one    = (pin_rd_q == PIN_W'(1));
  assign sts_o.pin_max    = (pin_rd_q == PIN_MAX);
  assign sts_o.scan_valid = tag_valid_q[scan_q];
  assign sts_o.scan_match = (cmd_q == CMD_EVICT_ALL) ||
                            (tag_rd_q[KEY_W-1 -: OWN_W] == owner_q);
  assign sts_o.scan_last  = (scan_q == SLOT_W'(NUM_SLOTS - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_slot_o     = out_slot_q;
  assign out_ev_valid_o = out_ev_valid_q;
  assign out_ev_owner_o = out_ev_owner_q;
  assign out_ev_line_o  = out_ev_line_q;
  assign out_free_o     = out_free_q;

endmodule

FILE: rtl/pinned_slot_cache_directory_unit.sv
// lookup: accept, select, then done if refused, else a pin count step, an unlink or a miss
// unpin: flags an unpinned slot, else a pin count step or a relink; evict: walks all slots, skips
// unmapped ones, keeps unmatched or pinned ones, unlinks evicted ones, then loads the result
// next word is taken the cycle after the result register loads, while it waits
// reset: line map clearing pass over all MAP_DEPTH (16384) entries, no words accepted meanwhile
// top level: joins psc_ctrl and psc_dp to the request and response channels
module pinned_slot_cache_directory_unit (
  input  logic    clk_i,
  input  logic    rst_ni,
  psc_in_if.sink  in_i,
  psc_out_if.source out_o
);
  import psc_pkg::*;

  psc_cmd_t ctrl_cmd;
  psc_sts_t dp_sts;

  psc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  psc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .sts_o          (dp_sts),
    .in_cmd_i       (in_i.cmd),
    .in_owner_i     (in_i.owner_id),
    .in_line_i      (in_i.line_index),
    .in_slot_i      (in_i.slot_index),
    .in_need_i      (in_i.lines_needed),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_status_o   (out_o.status),
    .out_slot_o     (out_o.slot_out),
    .out_ev_valid_o (out_o.evicted_valid),
    .out_ev_owner_o (out_o.evicted_owner),
    .out_ev_line_o  (out_o.evicted_line),
    .out_free_o     (out_o.free_slots)
  );

endmodule

FILE: rtl/psc_chk.sv
// port-level checks on the slot cache directory response channel
// bound to pinned_slot_cache_directory_unit; depends on psc_pkg
module psc_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [psc_pkg::ST_W-1:0]   status_i,
  input logic [psc_pkg::SLOT_W-1:0] slot_out_i,
  input logic                       evicted_valid_i,
  input logic [psc_pkg::CNT_W-1:0]  free_slots_i
);
  import psc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
    $stable(slot_out_i) && $stable(free_slots_i))
    else $error("response word changed while stalled");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> free_slots_i <= CNT_W'(NUM_SLOTS))
    else $error("free count above slot count");

  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && evicted_valid_i |-> status_i == ST_MISS)
    else $error("replaced line reported without a miss");

  a_no_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_NO_SPACE |-> slot_out_i == '0 && !evicted_valid_i)
    else $error("refused lookup gave a slot");

endmodule

bind pinned_slot_cache_directory_unit psc_chk u_psc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .slot_out_i      (out_o.slot_out),
  .evicted_valid_i (out_o.evicted_valid),
  .free_slots_i    (out_o.free_slots)
);
